>>> rtl/aas_pkg.sv
package aas_pkg;

  localparam int TimeBits  = 48;
  localparam int CountBits = 48;
  localparam int FracBits  = 16;
  localparam int RateBits  = 48;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 24;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_FULL_SAMPLING    = 3'd0,
    REG_MATCH_THRESHOLD  = 3'd1,
    REG_SAMPLE_TIME      = 3'd2,
    REG_FIRST_SAMPLES    = 3'd3,
    REG_MIN_MON_SAMPLES  = 3'd4,
    REG_MAX_MON_SAMPLES  = 3'd5,
    REG_MIN_PRED_SAMPLES = 3'd6,
    REG_MAX_PRED_SAMPLES = 3'd7
  } cfg_reg_t;

  localparam logic [23:0] RstMatchThreshold = 24'd6554;
  localparam logic [15:0] RstSampleTime     = 16'd1000;
  localparam logic [15:0] RstFirstSamples   = 16'd16;
  localparam logic [15:0] RstMinMon         = 16'd1;
  localparam logic [15:0] RstMaxMon         = 16'd64;
  localparam logic [15:0] RstMinPred        = 16'd1;
  localparam logic [15:0] RstMaxPred        = 16'd256;

endpackage

>>> rtl/adaptive_activity_sampler_unit.sv
// adaptive activity sampler
// input channel (in_valid/in_ready): one transaction per window-end event,
//   carrying the running toggle total and the current time
// output channel (out_valid/out_ready): exactly one result transaction per
//   event: next window length, monitored/predicted flag, global and local
//   rates (Q32.16) and the toggle estimate
// config channel (cfg_valid/cfg_ready): register index and data, always
//   ready; write only while no event is in flight
// one event is handled at a time: in_ready is low from acceptance until its
//   result is taken. latency is set by a shared 65-step serial divider, a
//   shared 24x32 multiplier and the sequencer around them: full sampling
//   runs one division, the initial event one multiply, running events one
//   division and the window multiply, and two divisions plus the rate
//   compare when a predicted window other than the first one closes
// a stalled receiver holds the result in place and the block takes no new
//   event until it is accepted
// synchronous reset returns configuration and block state registers to their
//   defaults and state to initial window pending
module adaptive_activity_sampler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] toggle_total,
  input  logic [47:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_interval,
  output logic        monitoring,
  output logic [47:0] global_rate,
  output logic [47:0] local_rate,
  output logic [47:0] toggle_estimate,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_FS_DIV, S_P0_MUL, S_P0_APPLY, S_R_DEN, S_R_GDIV, S_R_LDIV,
    S_R_CMP0, S_R_CMP1, S_R_CMP2, S_R_WMUL, S_R_WAPPLY, S_R_P1, S_R_P2, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic        full_sampling;
  logic [23:0] match_threshold;
  logic [15:0] sample_time, first_samples;
  logic [15:0] min_mon, max_mon, min_pred, max_pred;

  // block state
  logic [1:0]  phase;
  logic        sampling_now, first_monitor;
  logic [15:0] mon_count, pred_count;
  logic [47:0] mon_toggles, mon_begin, mon_end, total_mon_time, total_pred_time;
  logic [63:0] pred_toggles;
  logic [47:0] last_local_rate;

  // working registers
  logic [47:0] tog, now;
  logic [47:0] grate, lrate;
  logic [31:0] win, interval;
  logic        mon;
  logic [49:0] rem;
  logic [64:0] dsh;
  logic [48:0] den;
  logic        den_zero;
  logic [6:0]  cnt;
  logic [55:0] prod, acc;

  // divider step
  logic [49:0] r2, r_new;
  logic        ge;
  logic [64:0] d_new;
  logic [47:0] q_sat;

  always_comb begin
    r2    = {rem[48:0], dsh[64]};
    ge    = r2 >= {1'b0, den};
    r_new = ge ? r2 - {1'b0, den} : r2;
    d_new = {dsh[63:0], ge};
    if (den_zero) begin
      q_sat = '0;
    end else if (|d_new[64:48]) begin
      q_sat = '1;
    end else begin
      q_sat = d_new[47:0];
    end
  end

  // shared multiplier
  logic [23:0] mul_a;
  logic [31:0] mul_b;
  logic [47:0] mx, mn;
  logic [24:0] kq;

  always_comb begin
    mx = (lrate > grate) ? lrate : grate;
    mn = (lrate > grate) ? grate : lrate;
    kq = {1'b0, match_threshold} + 25'h10000;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_P0_MUL: begin
        mul_a = {8'd0, first_samples};
        mul_b = {16'd0, sample_time};
      end
      S_R_CMP0: begin
        mul_a = mn[23:0];
        mul_b = {7'd0, kq};
      end
      S_R_CMP1: begin
        mul_a = mn[47:24];
        mul_b = {7'd0, kq};
      end
      S_R_WMUL: begin
        mul_a = {8'd0, sampling_now ? mon_count : pred_count};
        mul_b = {16'd0, sample_time};
      end
      S_R_WAPPLY: begin
        mul_a = last_local_rate[23:0];
        mul_b = prod[31:0];
      end
      S_R_P1: begin
        mul_a = last_local_rate[47:24];
        mul_b = win;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // recombine the two partial products
  logic [80:0] full;
  logic        match_ok;
  logic [64:0] pt_sum;
  logic [63:0] pred_next;

  always_comb begin
    full      = {25'd0, acc} + {1'b0, prod, 24'd0};
    match_ok  = (mx != '0) && ({17'd0, mx, 16'd0} <= full);
    pt_sum    = {1'b0, pred_toggles} + {1'b0, full[63:0]};
    if ((|full[80:64]) || pt_sum[64]) begin
      pred_next = '1;
    end else begin
      pred_next = pt_sum[63:0];
    end
  end

  // time and count helpers
  logic [47:0] end_gap, mon_elapsed, ltc, mon_span, tog_max;
  logic [48:0] run_den;
  logic [48:0] tmt_sum, tpt_sum, est_sum;
  logic [48:0] mon_end_sum;
  logic        sn_new, fm_eff;

  always_comb begin
    end_gap = mon_end - now;
    if (mon_end > now) begin
      mon_elapsed = (total_mon_time > end_gap) ? total_mon_time - end_gap : '0;
    end else begin
      mon_elapsed = (total_mon_time > now) ? now : total_mon_time;
    end
    run_den     = {1'b0, mon_elapsed} + {1'b0, total_pred_time};
    ltc         = (tog > mon_toggles) ? tog - mon_toggles : '0;
    tog_max     = (tog > mon_toggles) ? tog : mon_toggles;
    mon_span    = (mon_end > mon_begin) ? mon_end - mon_begin : '0;
    tmt_sum     = {1'b0, total_mon_time} + {17'd0, prod[31:0]};
    tpt_sum     = {1'b0, total_pred_time} + {17'd0, prod[31:0]};
    mon_end_sum = {1'b0, now} + {17'd0, prod[31:0]};
    est_sum     = {1'b0, mon_toggles} + {1'b0, pred_toggles[63:16]};
    sn_new      = ~sampling_now;
    fm_eff      = (phase == 2'd1) ? 1'b1 : first_monitor;
  end

  function automatic logic [15:0] halve(input logic [15:0] n, input logic [15:0] lim);
    logic [15:0] t;
    t = {1'b0, n[15:1]};
    return (t >= lim) ? t : n;
  endfunction

  function automatic logic [15:0] twice(input logic [15:0] n, input logic [15:0] lim);
    logic [16:0] t;
    t = {n, 1'b0};
    return (t <= {1'b0, lim}) ? t[15:0] : n;
  endfunction

  assign in_ready        = (state == S_IDLE);
  assign out_valid       = (state == S_OUT);
  assign cfg_ready       = 1'b1;
  assign next_interval   = interval;
  assign monitoring      = mon;
  assign global_rate     = grate;
  assign local_rate      = last_local_rate;
  assign toggle_estimate = est_sum[48] ? '1 : est_sum[47:0];

  always_ff @(posedge clk) begin
    prod <= 56'(mul_a * mul_b);
    if (rst) begin
      state           <= S_IDLE;
      full_sampling   <= 1'b0;
      match_threshold <= aas_pkg::RstMatchThreshold;
      sample_time     <= aas_pkg::RstSampleTime;
      first_samples   <= aas_pkg::RstFirstSamples;
      min_mon         <= aas_pkg::RstMinMon;
      max_mon         <= aas_pkg::RstMaxMon;
      min_pred        <= aas_pkg::RstMinPred;
      max_pred        <= aas_pkg::RstMaxPred;
      phase           <= 2'd0;
      sampling_now    <= 1'b1;
      first_monitor   <= 1'b0;
      mon_count       <= aas_pkg::RstFirstSamples;
      pred_count      <= aas_pkg::RstMinPred;
      mon_toggles     <= '0;
      pred_toggles    <= '0;
      mon_begin       <= '0;
      mon_end         <= '0;
      total_mon_time  <= '0;
      total_pred_time <= '0;
      last_local_rate <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (aas_pkg::cfg_reg_t'(cfg_index))
          aas_pkg::REG_FULL_SAMPLING:    full_sampling   <= cfg_data[0];
          aas_pkg::REG_MATCH_THRESHOLD:  match_threshold <= cfg_data;
          aas_pkg::REG_SAMPLE_TIME:      sample_time     <= cfg_data[15:0];
          aas_pkg::REG_FIRST_SAMPLES:    first_samples   <= cfg_data[15:0];
          aas_pkg::REG_MIN_MON_SAMPLES:  min_mon         <= cfg_data[15:0];
          aas_pkg::REG_MAX_MON_SAMPLES:  max_mon         <= cfg_data[15:0];
          aas_pkg::REG_MIN_PRED_SAMPLES: min_pred        <= cfg_data[15:0];
          aas_pkg::REG_MAX_PRED_SAMPLES: max_pred        <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tog <= toggle_total;
            now <= now_time;
            if (full_sampling) begin
              sampling_now <= 1'b1;
              interval     <= '0;
              mon          <= 1'b1;
              rem          <= '0;
              dsh          <= {1'b0, toggle_total, 16'd0};
              den          <= {1'b0, now_time};
              den_zero     <= (now_time == '0);
              cnt          <= 7'd64;
              state        <= S_FS_DIV;
            end else if (phase == 2'd0) begin
              state <= S_P0_MUL;
            end else begin
              state <= S_R_DEN;
            end
          end
        end
        S_FS_DIV: begin
          rem <= r_new;
          dsh <= d_new;
          cnt <= cnt - 7'd1;
          if (cnt == '0) begin
            grate <= q_sat;
            state <= S_OUT;
          end
        end
        S_P0_MUL: begin
          phase      <= 2'd1;
          mon_count  <= first_samples;
          pred_count <= min_pred;
          state      <= S_P0_APPLY;
        end
        S_P0_APPLY: begin
          total_mon_time <= {16'd0, prod[31:0]};
          interval       <= prod[31:0];
          mon            <= 1'b1;
          grate          <= '0;
          state          <= S_OUT;
        end
        S_R_DEN: begin
          rem <= '0;
          cnt <= 7'd64;
          if (phase == 2'd1) begin
            dsh      <= {1'b0, tog, 16'd0};
            den      <= {1'b0, now};
            den_zero <= (now == '0);
          end else begin
            dsh      <= {1'b0, tog, 16'd0} + {1'b0, pred_toggles};
            den      <= run_den;
            den_zero <= (run_den == '0);
          end
          state <= S_R_GDIV;
        end
        S_R_GDIV: begin
          rem <= r_new;
          dsh <= d_new;
          cnt <= cnt - 7'd1;
          if (cnt == '0) begin
            grate        <= q_sat;
            sampling_now <= sn_new;
            if (phase == 2'd1) begin
              phase           <= 2'd2;
              mon_toggles     <= tog;
              mon_end         <= now;
              last_local_rate <= q_sat;
            end
            first_monitor <= fm_eff;
            if (sn_new && fm_eff) begin
              mon_count     <= halve(mon_count, min_mon);
              first_monitor <= 1'b0;
              state         <= S_R_WMUL;
            end else if (sn_new) begin
              // local rate of the last monitored window, taken when a predicted window closes
              rem      <= '0;
              dsh      <= {1'b0, ltc, 16'd0};
              den      <= {1'b0, mon_span};
              den_zero <= (mon_span == '0);
              cnt      <= 7'd64;
              state    <= S_R_LDIV;
            end else begin
              state <= S_R_WMUL;
            end
          end
        end
        S_R_LDIV: begin
          rem <= r_new;
          dsh <= d_new;
          cnt <= cnt - 7'd1;
          if (cnt == '0) begin
            lrate       <= q_sat;
            mon_toggles <= tog_max;
            state       <= S_R_CMP0;
          end
        end
        S_R_CMP0: begin
          state <= S_R_CMP1;
        end
        S_R_CMP1: begin
          acc   <= prod;
          state <= S_R_CMP2;
        end
        S_R_CMP2: begin
          if (match_ok) begin
            mon_count  <= halve(mon_count, min_mon);
            pred_count <= twice(pred_count, max_pred);
          end else begin
            mon_count  <= twice(mon_count, max_mon);
            pred_count <= halve(pred_count, min_pred);
          end
          last_local_rate <= lrate;
          state           <= S_R_WMUL;
        end
        S_R_WMUL: begin
          state <= S_R_WAPPLY;
        end
        S_R_WAPPLY: begin
          win      <= prod[31:0];
          interval <= prod[31:0];
          mon      <= sampling_now;
          if (sampling_now) begin
            mon_begin      <= now;
            mon_end        <= mon_end_sum[47:0];
            total_mon_time <= tmt_sum[48] ? '1 : tmt_sum[47:0];
            state          <= S_OUT;
          end else begin
            total_pred_time <= tpt_sum[48] ? '1 : tpt_sum[47:0];
            state           <= S_R_P1;
          end
        end
        S_R_P1: begin
          acc   <= prod;
          state <= S_R_P2;
        end
        S_R_P2: begin
          pred_toggles <= pred_next;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
